// ===== sv/mbld_pkg.sv =====
`timescale 1ns / 1ps

package mbld_pkg;

    localparam int SLOTS_DEF     = 5;
    localparam int PORT_BITS_DEF = 8;

    localparam int PORT_MAX   = 8;
    localparam int PIN_W      = 3;
    localparam int SLOT_W     = 3;
    localparam int COUNT_W    = 3;
    localparam int LOCK_W     = 16;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = CFG_IDX_W'(1);
    localparam int                   REG_PIN_BASE     = 2;
    localparam int                   PIN_REGS         = 5;

    localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(0);
    localparam logic [LOCK_W-1:0]  LOCKOUT_RESET = LOCK_W'(50);

    // event token handed from cell to cell
    typedef struct packed {
        logic                valid;
        logic [PORT_MAX-1:0] port;
        logic [TIME_W-1:0]   evt_time;
    } token_t;

endpackage

// ===== sv/mbld_cell.sv =====
`timescale 1ns / 1ps

module mbld_cell #(
    parameter int SLOT_ID = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mbld_pkg::token_t              tok_in,
    input  logic                          enable,
    input  logic [mbld_pkg::LOCK_W-1:0]   lockout,
    input  logic                          pin_we,
    input  logic [mbld_pkg::PIN_W-1:0]    pin_wdata,
    input  logic                          clear,
    output mbld_pkg::token_t              tok_out,
    output logic                          fire,
    output logic                          level
);
    import mbld_pkg::*;

    localparam logic [PIN_W-1:0] PIN_RESET = PIN_W'(SLOT_ID % PORT_MAX);

    token_t             tok_reg;
    logic [PIN_W-1:0]   pin_reg;
    logic [TIME_W-1:0]  deadline_reg;
    logic               level_reg;
    logic               fire_reg;
    logic               unlocked;
    logic               pin_level;

    assign unlocked  = tok_in.evt_time > deadline_reg;
    assign pin_level = tok_in.port[pin_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg       <= '0;
            pin_reg       <= PIN_RESET;
            deadline_reg  <= '0;
            level_reg     <= 1'b1;
            fire_reg      <= 1'b0;
        end else begin
            tok_reg       <= tok_in;
            if (pin_we) begin
                pin_reg <= pin_wdata;
            end
            if (clear) begin
                fire_reg <= 1'b0;
            end
            if (tok_in.valid && enable && unlocked) begin
                deadline_reg <= tok_in.evt_time + TIME_W'(lockout);
                if (pin_level != level_reg) begin
                    level_reg <= pin_level;
                    fire_reg  <= 1'b1;
                end
            end
        end
    end

    assign tok_out = tok_reg;
    assign fire    = fire_reg;
    assign level   = level_reg;

endmodule

// ===== sv/mbld_emit.sv =====
`timescale 1ns / 1ps

module mbld_emit #(
    parameter int SLOTS = mbld_pkg::SLOTS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             busy,
    input  logic [SLOTS-1:0] fire,
    input  logic [SLOTS-1:0] level,
    output logic [SLOTS-1:0] clear,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import mbld_pkg::*;

    logic [SLOTS-1:0]  sel;
    logic [SLOT_W-1:0] idx;
    logic              picked;
    logic              seen;
    logic              load;
    logic              valid_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              level_reg;
    logic              last_reg;

    // lowest pending slot goes first
    always_comb begin
        seen   = 1'b0;
        sel    = '0;
        idx    = '0;
        picked = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (fire[i] && !seen) begin
                sel[i] = 1'b1;
                idx    = SLOT_W'(i);
                picked = level[i];
            end
            seen = seen | fire[i];
        end
    end

    assign load  = !busy && (|fire) && (!valid_reg || m_tready);
    assign clear = load ? sel : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            slot_reg  <= idx;
            level_reg <= picked;
            last_reg  <= (fire & ~sel) == '0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, level_reg, slot_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== sv/multi_button_lockout_debouncer.sv =====
`timescale 1ns / 1ps

// Lockout debouncer for up to SLOTS buttons on one port. Each input transfer is a
// port-change event (port snapshot plus 32-bit tick time). The event token walks a
// row of one cell per button slot, one slot per cycle; a slot whose deadline has
// passed (strict unsigned compare, no wrap handling) re-arms to time + lockout and,
// if its pin level differs from the stored level, raises a change. After the token
// leaves the row, changes go out in slot order, one per cycle while m_tready is
// high, tlast on the final one. The next event is taken once every change of the
// current one has been moved into the output register. Stored levels reset high,
// deadlines to zero; pins at or beyond PORT_BITS read low.
module multi_button_lockout_debouncer #(
    parameter int SLOTS     = mbld_pkg::SLOTS_DEF,
    parameter int PORT_BITS = mbld_pkg::PORT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // port_levels [PORT_BITS-1:0], event_time [PORT_BITS+31:PORT_BITS]
    input  logic [((PORT_BITS+39)/8)*8-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // button_slot [2:0], new_level [3]
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [mbld_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbld_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import mbld_pkg::*;

    logic [COUNT_W-1:0]  button_count_reg;
    logic [LOCK_W-1:0]   lockout_reg;
    logic [PORT_MAX-1:0] port_ext;
    token_t              tok [SLOTS+1];
    logic [SLOTS:0]      tok_valid;
    logic [SLOTS-1:0]    fire;
    logic [SLOTS-1:0]    level;
    logic [SLOTS-1:0]    clear;
    logic                busy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_count_reg <= COUNT_RESET;
            lockout_reg      <= LOCKOUT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_BUTTON_COUNT) begin
                button_count_reg <= cfg_wdata[COUNT_W-1:0];
            end
            if (cfg_index == REG_LOCKOUT) begin
                lockout_reg <= cfg_wdata[LOCK_W-1:0];
            end
        end
    end

    // pins beyond the port read low
    for (genvar k = 0; k < PORT_MAX; k++) begin : g_port
        if (k < PORT_BITS) begin : g_live
            assign port_ext[k] = s_tdata[k];
        end else begin : g_zero
            assign port_ext[k] = 1'b0;
        end
    end

    assign s_tready       = !busy && (fire == '0);
    assign tok[0].valid    = s_tvalid && s_tready;
    assign tok[0].port     = port_ext;
    assign tok[0].evt_time = s_tdata[PORT_BITS +: TIME_W];

    for (genvar i = 0; i <= SLOTS; i++) begin : g_valid
        assign tok_valid[i] = tok[i].valid;
    end
    assign busy = |tok_valid[SLOTS:1];

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        logic pin_we;
        logic enable;

        if (i < PIN_REGS) begin : g_pin
            assign pin_we = cfg_we && (cfg_index == CFG_IDX_W'(REG_PIN_BASE + i));
        end else begin : g_fixed
            assign pin_we = 1'b0;
        end
        assign enable = button_count_reg > COUNT_W'(i);

        mbld_cell #(
            .SLOT_ID (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .tok_in    (tok[i]),
            .enable    (enable),
            .lockout   (lockout_reg),
            .pin_we    (pin_we),
            .pin_wdata (cfg_wdata[PIN_W-1:0]),
            .clear     (clear[i]),
            .tok_out   (tok[i+1]),
            .fire      (fire[i]),
            .level     (level[i])
        );
    end

    mbld_emit #(
        .SLOTS (SLOTS)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .busy     (busy),
        .fire     (fire),
        .level    (level),
        .clear    (clear),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
